>>> hdl/node_id_allocator_with_aging_top_defines.svh
// Assertion helpers for the allocator control logic.
`ifndef NODE_ID_ALLOCATOR_WITH_AGING_TOP_DEFINES_SVH
`define NODE_ID_ALLOCATOR_WITH_AGING_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define NIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nia check failed");

// Next-cycle implication.
`define NIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nia check failed");

`endif

>>> hdl/nia_pkg.sv
package nia_pkg;

	localparam int NUM_IDS_DEF    = 256;
	localparam int PEND_DEPTH_DEF = 16;
	localparam int MAX_PAIRS_DEF  = 16;
	localparam int GATEWAY_ID_DEF = 0;

	localparam logic [6:0] STAMP_MASK = 7'h7F;

	localparam logic [1:0] REQ_DATA  = 2'd0;
	localparam logic [1:0] REQ_IDREQ = 2'd1;
	localparam logic [1:0] REQ_BCAST = 2'd2;

	localparam logic [6:0] MAX_MISSES_RST     = 7'd3;
	localparam logic [4:0] FEEDBACK_PAIRS_RST = 5'd8;

	localparam logic REG_MAX_MISSES     = 1'b0;
	localparam logic REG_FEEDBACK_PAIRS = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  dest_id;
		logic [7:0]  node_id;
		logic [31:0] node_key;
	} in_item_t;

	typedef struct packed {
		logic [7:0] fb_id;
		logic [7:0] fb_response;
		logic       first_bcast;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [6:0] max_misses;
		logic [4:0] feedback_pairs;
	} cfg_t;

endpackage

>>> hdl/node_id_allocator_with_aging_top.sv
// Network-ID allocator with aging. After reset the block clears its NUM_IDS-entry
// id table (256 entries by default), one entry a cycle, before taking
// beats. One item is worked on at a time through the table and pending-queue
// memories: a data message is a table read then a stamp write, an id request
// is a queue scan, a check of its own id and a descending table search (each
// scan one entry a cycle) before enqueueing, and a broadcast emits its pairs
// one at a time through a head read and an output state, stretched by any output
// stall; a new beat is taken only once the last pair has left.
module node_id_allocator_with_aging_top #(
	parameter int NUM_IDS    = nia_pkg::NUM_IDS_DEF,
	parameter int PEND_DEPTH = nia_pkg::PEND_DEPTH_DEF,
	parameter int MAX_PAIRS  = nia_pkg::MAX_PAIRS_DEF,
	parameter int GATEWAY_ID = nia_pkg::GATEWAY_ID_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  nia_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nia_pkg::out_item_t out_data
);

	nia_pkg::cfg_t cfg;

	nia_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	nia_ctrl #(
		.NUM_IDS(NUM_IDS), .PEND_DEPTH(PEND_DEPTH),
		.MAX_PAIRS(MAX_PAIRS), .GATEWAY_ID(GATEWAY_ID)
	) u_ctrl (
		.clk, .arst_n, .cfg, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data
	);

endmodule

>>> hdl/nia_ram.sv
module nia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/nia_cfg.sv
module nia_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output nia_pkg::cfg_t   cfg
);

	logic [6:0] max_misses_q;
	logic [4:0] feedback_pairs_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_misses_q     <= nia_pkg::MAX_MISSES_RST;
			feedback_pairs_q <= nia_pkg::FEEDBACK_PAIRS_RST;
		end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == nia_pkg::REG_MAX_MISSES) begin
			max_misses_q <= pwdata[6:0];
		end else if (wr && paddr[1:0] == 2'b00
				&& paddr[2] == nia_pkg::REG_FEEDBACK_PAIRS) begin
			feedback_pairs_q <= pwdata[4:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				nia_pkg::REG_MAX_MISSES:     prdata = {25'd0, max_misses_q};
				nia_pkg::REG_FEEDBACK_PAIRS: prdata = {27'd0, feedback_pairs_q};
				default:                     prdata = '0;
			endcase
		end
	end

	assign cfg.max_misses     = max_misses_q;
	assign cfg.feedback_pairs = feedback_pairs_q;

endmodule

>>> hdl/nia_ctrl.sv
`include "node_id_allocator_with_aging_top_defines.svh"

module nia_ctrl #(
	parameter int NUM_IDS    = nia_pkg::NUM_IDS_DEF,
	parameter int PEND_DEPTH = nia_pkg::PEND_DEPTH_DEF,
	parameter int MAX_PAIRS  = nia_pkg::MAX_PAIRS_DEF,
	parameter int GATEWAY_ID = nia_pkg::GATEWAY_ID_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nia_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  nia_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nia_pkg::out_item_t  out_data
);

	localparam int IW = $clog2(NUM_IDS);
	localparam int PW = $clog2(PEND_DEPTH);
	localparam int CW = $clog2(PEND_DEPTH + 1);
	localparam int NW = $clog2(MAX_PAIRS + 1);
	localparam logic [IW:0] TOP_ID = (IW + 1)'(NUM_IDS - 1);
	localparam logic [IW:0] GW = (IW + 1)'(GATEWAY_ID);
	localparam int TW = 8;   // used bit + stamp

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TREAD  = 4'd1;  // table read wait
	localparam logic [3:0] ST_DATA   = 4'd2;
	localparam logic [3:0] ST_PSCAN  = 4'd3;  // pending scan, read issued
	localparam logic [3:0] ST_PCHK   = 4'd4;
	localparam logic [3:0] ST_REQCHK = 4'd5;
	localparam logic [3:0] ST_SSCAN  = 4'd6;  // descending search
	localparam logic [3:0] ST_ENQ    = 4'd7;
	localparam logic [3:0] ST_BREAD  = 4'd8;
	localparam logic [3:0] ST_BOUT   = 4'd9;
	localparam logic [3:0] ST_CLEAR  = 4'd10;
	localparam logic [3:0] ST_SWAIT  = 4'd11;

	logic [3:0]  state_q;
	nia_pkg::in_item_t item_q;
	logic [IW:0] clr_q;
	logic [6:0]  bcnt_q;
	logic        first_q;
	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic [IW:0]   scan_q;
	logic [7:0]    resp_q;
	logic [NW-1:0] pairs_q;
	logic [NW-1:0] p_q;
	logic          out_valid_q;
	nia_pkg::out_item_t out_q;

	// table memory
	logic          t_we;
	logic [IW-1:0] t_waddr, t_raddr;
	logic [TW-1:0] t_wdata, t_rdata;
	// pending memories
	logic          p_we, pr_we;
	logic [PW-1:0] p_waddr, p_raddr;
	logic [7:0]    pid_rdata, presp_rdata, presp_wdata;
	logic [31:0]   pkey_rdata;

	nia_ram #(.WIDTH(TW), .DEPTH(NUM_IDS)) u_tab (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
	);
	nia_ram #(.WIDTH(8), .DEPTH(PEND_DEPTH)) u_pid (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(item_q.node_id),
		.raddr(p_raddr), .rdata(pid_rdata)
	);
	nia_ram #(.WIDTH(8), .DEPTH(PEND_DEPTH)) u_presp (
		.clk, .we(pr_we), .waddr(p_waddr), .wdata(presp_wdata),
		.raddr(p_raddr), .rdata(presp_rdata)
	);
	nia_ram #(.WIDTH(32), .DEPTH(PEND_DEPTH)) u_pkey (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(item_q.node_key),
		.raddr(p_raddr), .rdata(pkey_rdata)
	);

	logic        t_free;
	logic [6:0]  age;
	logic [PW-1:0] k_slot, tail_slot;
	logic [PW:0]   k_sum, t_sum;
	logic [NW-1:0] pairs_n;
	logic        node_in;

	assign age    = (bcnt_q - t_rdata[6:0]) & nia_pkg::STAMP_MASK;
	assign t_free = !t_rdata[7] || (age >= cfg.max_misses);
	assign node_in = {1'b0, item_q.node_id} <= {1'b0, TOP_ID[IW:0] > 8'hFF ? 8'hFF : 8'(TOP_ID)};

	// modular slot indices; sums stay below twice the depth
	assign k_sum  = {1'b0, head_q} + (PW + 1)'(k_q);
	assign t_sum  = {1'b0, head_q} + (PW + 1)'(count_q);
	assign k_slot = (k_sum >= (PW + 1)'(PEND_DEPTH)) ? PW'(k_sum - (PW + 1)'(PEND_DEPTH))
		: PW'(k_sum);
	assign tail_slot = (t_sum >= (PW + 1)'(PEND_DEPTH)) ? PW'(t_sum - (PW + 1)'(PEND_DEPTH))
		: PW'(t_sum);

	always_comb begin
		if (cfg.feedback_pairs == 5'd0) begin
			pairs_n = NW'(1);
		end else if ({3'd0, cfg.feedback_pairs} > 8'(MAX_PAIRS)) begin
			pairs_n = NW'(MAX_PAIRS);
		end else begin
			pairs_n = NW'(cfg.feedback_pairs);
		end
	end

	always_comb begin
		t_we    = 1'b0;
		t_waddr = IW'(item_q.node_id);
		t_wdata = {1'b1, bcnt_q};
		t_raddr = IW'(item_q.node_id);
		p_we    = 1'b0;
		pr_we   = 1'b0;
		p_waddr = tail_slot;
		presp_wdata = resp_q;
		p_raddr = k_slot;
		case (state_q)
			ST_CLEAR: begin
				t_we    = 1'b1;
				t_waddr = clr_q[IW-1:0];
				t_wdata = '0;
			end
			ST_DATA: t_we = node_in;
			ST_PCHK: begin
				// rdata holds slot k-1 of the queue
				if (k_q <= count_q && pid_rdata == item_q.node_id
						&& pkey_rdata != item_q.node_key) begin
					pr_we       = 1'b1;
					p_waddr     = (k_slot == '0) ? PW'(PEND_DEPTH - 1)
						: PW'(k_slot - PW'(1));
					presp_wdata = 8'd0;
					t_we        = node_in;
					t_wdata     = {1'b0, t_rdata[6:0]};
				end
			end
			ST_REQCHK: t_we = node_in && t_free;
			ST_SWAIT: t_raddr = IW'(scan_q + (IW + 1)'(1));
			ST_SSCAN: begin
				t_raddr = scan_q[IW-1:0];
				t_waddr = IW'(scan_q + (IW + 1)'(1));
				t_we    = t_free && (scan_q + (IW + 1)'(1)) <= TOP_ID;
			end
			ST_ENQ: begin
				p_we  = count_q < CW'(PEND_DEPTH);
				pr_we = p_we;
			end
			ST_BREAD: p_raddr = head_q;
			// keep the head read while the beat waits
			ST_BOUT: p_raddr = head_q;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			bcnt_q      <= '0;
			first_q     <= 1'b1;
			head_q      <= '0;
			count_q     <= '0;
			k_q         <= '0;
			scan_q      <= '0;
			p_q         <= '0;
			pairs_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_BOUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + (IW + 1)'(1);
					if (clr_q == TOP_ID) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						k_q    <= '0;
						resp_q <= '0;
						if (in_data.dest_id != 8'(GATEWAY_ID)
								&& in_data.req_type != nia_pkg::REQ_BCAST) begin
							state_q <= ST_IDLE;
						end else begin
							case (in_data.req_type)
								nia_pkg::REQ_DATA:  state_q <= ST_TREAD;
								nia_pkg::REQ_IDREQ: state_q <= ST_PSCAN;
								nia_pkg::REQ_BCAST: begin
									pairs_q <= pairs_n;
									p_q     <= '0;
									state_q <= ST_BREAD;
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					end
				end
				ST_TREAD: state_q <= ST_DATA;
				ST_DATA:  state_q <= ST_IDLE;
				ST_PSCAN: begin
					// read of slot k issued; advance k so rdata lines up with k-1
					k_q     <= k_q + CW'(1);
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					if (k_q <= count_q && pid_rdata == item_q.node_id) begin
						state_q <= ST_IDLE;
					end else if (k_q >= count_q) begin
						state_q <= ST_REQCHK;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				ST_REQCHK: begin
					if (node_in && t_free) begin
						resp_q  <= item_q.node_id;
						state_q <= ST_ENQ;
					end else if (TOP_ID > GW) begin
						scan_q  <= TOP_ID - (IW + 1)'(1);
						state_q <= ST_SWAIT;
					end else begin
						state_q <= ST_ENQ;
					end
				end
				ST_SWAIT: state_q <= ST_SSCAN;
				ST_SSCAN: begin
					// rdata belongs to scan_q + 1
					if (t_free) begin
						resp_q  <= 8'(scan_q + (IW + 1)'(1));
						state_q <= ST_ENQ;
					end else if (scan_q == GW) begin
						state_q <= ST_ENQ;
					end else begin
						scan_q <= scan_q - (IW + 1)'(1);
					end
				end
				ST_ENQ: begin
					if (count_q < CW'(PEND_DEPTH)) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_BREAD: state_q <= ST_BOUT;
				ST_BOUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						out_q.first_bcast <= first_q;
						out_q.last      <= (p_q + NW'(1)) == pairs_q;
						if (count_q != '0) begin
							out_q.fb_id       <= pid_rdata;
							out_q.fb_response <= presp_rdata;
							head_q  <= (head_q == PW'(PEND_DEPTH - 1)) ? '0
								: PW'(head_q + PW'(1));
							count_q <= count_q - CW'(1);
						end else begin
							out_q.fb_id       <= 8'd0;
							out_q.fb_response <= 8'd0;
						end
						p_q <= p_q + NW'(1);
						if ((p_q + NW'(1)) == pairs_q) begin
							bcnt_q  <= bcnt_q + 7'd1;
							first_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_BREAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NIA_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CW'(PEND_DEPTH))
	`NIA_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`NIA_ASSERT_NEXT(a_bcnt_step, clk, arst_n,
		out_valid_q && out_ready && out_q.last, !first_q)

endmodule
